@@ hw/rtl/pwrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwrm_pkg
// Shared types and constants for the windowed RMS level meter.
// ============================================================================
package pwrm_pkg;

    // Window capacity and the widths that follow from it
    localparam int MAX_WINDOW_SAMPLES = 16384;
    localparam int TALLY_W            = $clog2(MAX_WINDOW_SAMPLES + 1);

    // Fixed-point widths: Q1.23 magnitude, Q1.46 square, 60-bit square sum
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 47;
    localparam int SUM_W   = 60;
    localparam int SUM_SH  = 14;
    localparam int DIVD_W  = SUM_W - SUM_SH;
    localparam int LEVEL_W = 16;
    localparam int ROOT_IN = 2 * LEVEL_W;
    localparam int REM_W   = LEVEL_W + 1;
    localparam int ALU_W   = REM_W + 2;
    localparam int CNT_W   = $clog2(DIVD_W);

    // Sample format codes
    localparam logic [2:0] FMT_U8   = 3'd0;
    localparam logic [2:0] FMT_S16  = 3'd1;
    localparam logic [2:0] FMT_S24  = 3'd2;
    localparam logic [2:0] FMT_S32  = 3'd3;
    localparam logic [2:0] FMT_F32  = 3'd4;
    localparam logic [2:0] FMT_NONE = 3'd5;
    localparam logic [2:0] FMT_RESET = FMT_S16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } t_state;

    // Result of the shared subtract-and-compare unit
    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } t_sub_res;

endpackage
`default_nettype wire

@@ hw/rtl/pwrm_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwrm_decode
// Turns one raw PCM word into the Q1.23 magnitude for the configured format.
// ============================================================================
module pwrm_decode (
    input  wire logic [31:0]                 i_raw,
    input  wire logic [2:0]                  i_fmt,
    output logic [pwrm_pkg::MAG_W-1:0]       o_mag
);
    import pwrm_pkg::*;

    logic [7:0]  u8_dist;
    logic [15:0] s16_mag;
    logic [23:0] s24_mag;
    logic [23:0] s32_mag;
    logic [7:0]  f_ex;
    logic [22:0] f_man;
    logic [7:0]  f_sh;
    logic [24:0] f_round;
    logic [24:0] f_shift;
    logic [MAG_W-1:0] f_mag;

    localparam logic [MAG_W-1:0] Q23_ONE = MAG_W'(1) << (MAG_W - 1);

    always_comb begin
        u8_dist = i_raw[7] ? (i_raw[7:0] - 8'd128) : (8'd128 - i_raw[7:0]);
        s16_mag = i_raw[15] ? (16'd0 - i_raw[15:0]) : i_raw[15:0];
        s24_mag = i_raw[23] ? (24'd0 - i_raw[23:0]) : i_raw[23:0];
        s32_mag = i_raw[31] ? (24'd0 - i_raw[31:8]) : i_raw[31:8];
    end

    // Float: round to nearest with ties away from zero by adding half an LSB
    // before the right shift; magnitudes of one and above clamp to full scale.
    always_comb begin
        f_ex    = i_raw[30:23];
        f_man   = i_raw[22:0];
        f_sh    = 8'd127 - f_ex;
        f_round = '0;
        f_shift = '0;
        f_mag   = '0;
        if (f_ex == 8'hFF && f_man != 23'd0) begin
            f_mag = '0;
        end else if (f_ex >= 8'd127) begin
            f_mag = Q23_ONE;
        end else if (f_ex == 8'd0 || f_sh > 8'd24) begin
            f_mag = '0;
        end else begin
            f_round = {2'b01, f_man} + (25'd1 << (f_sh[4:0] - 5'd1));
            f_shift = f_round >> f_sh[4:0];
            f_mag   = (f_shift > 25'(Q23_ONE)) ? Q23_ONE : f_shift[MAG_W-1:0];
        end
    end

    always_comb begin
        case (i_fmt)
            FMT_U8:  o_mag = {u8_dist, 16'd0};
            FMT_S16: o_mag = {s16_mag, 8'd0};
            FMT_S24: o_mag = s24_mag;
            FMT_S32: o_mag = s32_mag;
            FMT_F32: o_mag = f_mag;
            default: o_mag = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/pwrm_subcmp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwrm_subcmp
// Shared subtract-and-compare unit for the divider and square-root steps.
// ============================================================================
module pwrm_subcmp (
    input  wire logic [pwrm_pkg::ALU_W-1:0] i_a,
    input  wire logic [pwrm_pkg::ALU_W-1:0] i_b,
    output pwrm_pkg::t_sub_res              o_res
);
    import pwrm_pkg::*;

    logic [ALU_W:0] full;

    always_comb begin
        full       = {1'b0, i_a} - {1'b0, i_b};
        o_res.ge   = ~full[ALU_W];
        o_res.diff = full[ALU_W-1:0];
    end

endmodule
`default_nettype wire

@@ hw/rtl/pcm_window_rms_meter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pcm_window_rms_meter_top
// Windowed RMS level meter: decode, square, accumulate, then divide and root.
// ============================================================================
// Each sample beat goes through accept, decode, square and accumulate, and
// the input is not ready until that is done. A sample marked last then runs a
// restoring divide of the top 46 bits of the square sum by the sample count
// (46 steps) and a digit-by-digit square root (16 steps), both through one
// shared subtract-and-compare unit, then a done state hands the result over.
// The root is skipped when the level saturates, and both when the window is
// empty. The result sits in an output register; the done state waits until
// that register is free, and a new window starts once the result is loaded.
module pcm_window_rms_meter_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [2:0]                    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [31:0]                   i_sample_raw,
    input  wire logic                          i_last_in_window,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [pwrm_pkg::LEVEL_W-1:0]       o_rms_level,
    output logic [pwrm_pkg::TALLY_W-1:0]       o_samples_counted,
    output logic                               o_window_overflow
);
    import pwrm_pkg::*;

    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIVD_W - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(LEVEL_W - 1);
    localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

    t_state r_state, n_state;
    logic [2:0]         r_fmt;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [TALLY_W-1:0] r_tally, n_tally;
    logic               r_ovf, n_ovf;
    logic               r_out_valid, n_out_valid;

    logic [31:0]        r_raw, n_raw;
    logic               r_last, n_last;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [DIVD_W-1:0]  r_work, n_work;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [LEVEL_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    logic [TALLY_W-1:0] r_out_count, n_out_count;
    logic               r_out_ovf, n_out_ovf;

    logic [MAG_W-1:0]   dec_mag;
    logic [2*MAG_W-1:0] product;
    logic [SUM_W:0]     sum_add;
    logic [ALU_W-1:0]   alu_a, alu_b;
    t_sub_res           alu_res;
    logic               load_out;

    pwrm_decode u_decode (
        .i_raw (r_raw),
        .i_fmt (r_fmt),
        .o_mag (dec_mag)
    );

    pwrm_subcmp u_subcmp (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Operand selection for the shared unit
    always_comb begin
        if (r_state == ST_ROOT) begin
            alu_a = {r_rem, r_work[ROOT_IN-1 -: 2]};
            alu_b = {1'b0, r_root, 2'b01};
        end else begin
            alu_a = {{(ALU_W-TALLY_W-1){1'b0}}, r_rem[TALLY_W-1:0], r_work[DIVD_W-1]};
            alu_b = {{(ALU_W-TALLY_W){1'b0}}, r_tally};
        end
    end

    always_comb begin
        product = r_mag * r_mag;
        sum_add = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_tally     = r_tally;
        n_ovf       = r_ovf;
        n_raw       = r_raw;
        n_last      = r_last;
        n_mag       = r_mag;
        n_sq        = r_sq;
        n_work      = r_work;
        n_rem       = r_rem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_out_level = r_out_level;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        load_out    = 1'b0;
        o_in_ready  = (r_state == ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_raw   = i_sample_raw;
                    n_last  = i_last_in_window;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_mag   = dec_mag;
                n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                n_sq    = product[SQ_W-1:0];
                n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (r_tally < TALLY_W'(MAX_WINDOW_SAMPLES)) begin
                    n_sum   = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
                    n_tally = r_tally + TALLY_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
                n_work = n_sum[SUM_W-1:SUM_SH];
                n_rem  = '0;
                n_root = '0;
                n_cnt  = '0;
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (n_tally == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // One quotient bit a cycle, shifted into the dividend register
                n_rem  = alu_res.ge ? alu_res.diff[REM_W-1:0]
                                    : alu_a[REM_W-1:0];
                n_work = {r_work[DIVD_W-2:0], alu_res.ge};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_cnt = '0;
                    n_rem = '0;
                    if (n_work[DIVD_W-1:ROOT_IN] != '0) begin
                        n_root  = '1;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                n_rem  = alu_res.ge ? alu_res.diff[REM_W-1:0]
                                    : alu_a[REM_W-1:0];
                n_root = {r_root[LEVEL_W-2:0], alu_res.ge};
                n_work = {r_work[DIVD_W-3:0], 2'b00};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == ROOT_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_level = r_root;
                    n_out_count = r_tally;
                    n_out_ovf   = r_ovf;
                    n_sum       = '0;
                    n_tally     = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = load_out || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fmt       <= FMT_RESET;
            r_sum       <= '0;
            r_tally     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_tally     <= n_tally;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw       <= n_raw;
        r_last      <= n_last;
        r_mag       <= n_mag;
        r_sq        <= n_sq;
        r_work      <= n_work;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_cnt       <= n_cnt;
        r_out_level <= n_out_level;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid       = r_out_valid;
    assign o_rms_level       = r_out_level;
    assign o_samples_counted = r_out_count;
    assign o_window_overflow = r_out_ovf;

endmodule
`default_nettype wire

@@ hw/rtl/pwrm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// pwrm_checker
// Port-level checks on the RMS meter, bound to the top level.
// ============================================================================
module pwrm_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [pwrm_pkg::LEVEL_W-1:0]  o_rms_level,
    input  wire logic [pwrm_pkg::TALLY_W-1:0]  o_samples_counted,
    input  wire logic                          o_window_overflow
);
    import pwrm_pkg::*;

    // A result beat that is not taken holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rms_level)
            && $stable(o_samples_counted) && $stable(o_window_overflow))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_samples_counted <= TALLY_W'(MAX_WINDOW_SAMPLES))
        else $error("sample count beyond window capacity");

    // Samples are only dropped once the window is full.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_window_overflow
            |-> o_samples_counted == TALLY_W'(MAX_WINDOW_SAMPLES))
        else $error("overflow flagged on a window that was not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_samples_counted == '0 |-> o_rms_level == '0)
        else $error("non-zero level for an empty window");

endmodule

bind pcm_window_rms_meter_top pwrm_checker u_pwrm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_rms_level       (o_rms_level),
    .o_samples_counted (o_samples_counted),
    .o_window_overflow (o_window_overflow)
);
`default_nettype wire
